FILE: design/fcpf_pkg.sv
// shared constants for the falling-count peak finder
package fcpf_pkg;

  // width of the sample index and of the result index field
  localparam int IDX_W = 16;
  // width of the timestamp
  localparam int TIME_W = 32;
  // width and ceiling of the fall counter
  localparam int FALL_W = 10;
  localparam logic [FALL_W-1:0] FALL_MAX = '1;
  localparam logic [FALL_W-1:0] FALL_LIMIT_RESET = FALL_W'(3);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_LIMIT = 1'b1;

endpackage

FILE: design/fcpf_if.sv
// stream interfaces for samples in and peak results out
interface fcpf_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [fcpf_pkg::TIME_W-1:0]   sample_time;
  logic                          first_of_trace;
  logic                          last_of_trace;

  modport source (
    output valid, sample, sample_time, first_of_trace, last_of_trace,
    input  ready
  );
  modport sink (
    input  valid, sample, sample_time, first_of_trace, last_of_trace,
    output ready
  );
endinterface

interface fcpf_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [fcpf_pkg::IDX_W-1:0]    peak_index;
  logic signed [SAMPLE_BITS-1:0] peak_value;
  logic [fcpf_pkg::TIME_W-1:0]   peak_time;
  logic                          no_peak;
  logic                          end_of_trace;

  modport source (
    output valid, peak_index, peak_value, peak_time, no_peak, end_of_trace,
    input  ready
  );
  modport sink (
    input  valid, peak_index, peak_value, peak_time, no_peak, end_of_trace,
    output ready
  );
endinterface

FILE: design/fcpf_core.sv
// per-sample peak search: trace state, configuration registers and step logic
module fcpf_core #(
  parameter int MAX_TRACE_LENGTH = 65536,
  parameter int SAMPLE_BITS      = 16,
  parameter int CFG_W            = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fcpf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]                  cfg_data_i,
  input  logic                              step_i,
  input  logic signed [SAMPLE_BITS-1:0]     sample_i,
  input  logic [fcpf_pkg::TIME_W-1:0]       sample_time_i,
  input  logic                              first_i,
  input  logic                              last_i,
  output logic                              res_valid_o,
  output logic [fcpf_pkg::IDX_W-1:0]        res_index_o,
  output logic signed [SAMPLE_BITS-1:0]     res_value_o,
  output logic [fcpf_pkg::TIME_W-1:0]       res_time_o,
  output logic                              res_no_peak_o,
  output logic                              res_eot_o
);

  localparam int IdxW   = fcpf_pkg::IDX_W;
  localparam int FallW  = fcpf_pkg::FALL_W;
  localparam int IdxTop = (MAX_TRACE_LENGTH - 1 > 65535) ? 65535 : MAX_TRACE_LENGTH - 1;
  localparam logic [IdxW-1:0] IdxLimit = IdxW'(IdxTop);
  localparam logic signed [SAMPLE_BITS-1:0] MarkerValue = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  logic signed [SAMPLE_BITS-1:0] thr_q;
  logic [FallW-1:0]              limit_q;

  logic signed [SAMPLE_BITS-1:0] prev_q, prev_d;
  logic signed [SAMPLE_BITS-1:0] rmax_q, rmax_d;
  logic [IdxW-1:0]               midx_q, midx_d;
  logic [fcpf_pkg::TIME_W-1:0]   mtime_q, mtime_d;
  logic                          pulse_q, pulse_d;
  logic [FallW-1:0]              fall_q, fall_d;
  logic [IdxW-1:0]               cnt_q, cnt_d;
  logic                          any_q, any_d;

  logic [IdxW-1:0]               cnt_inc;
  logic                          falling;
  logic signed [SAMPLE_BITS-1:0] rmax_p;
  logic [IdxW-1:0]               midx_p;
  logic [fcpf_pkg::TIME_W-1:0]   mtime_p;
  logic [FallW-1:0]              fall_p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= '0;
      limit_q <= fcpf_pkg::FALL_LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fcpf_pkg::CFG_THRESHOLD:  thr_q   <= cfg_data_i[SAMPLE_BITS-1:0];
        fcpf_pkg::CFG_FALL_LIMIT: limit_q <= cfg_data_i[FallW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_inc = (cnt_q < IdxLimit) ? cnt_q + IdxW'(1) : cnt_q;
    falling = sample_i < prev_q;

    // pulse update before the close decision
    if (sample_i > rmax_q) begin
      rmax_p  = sample_i;
      midx_p  = cnt_inc;
      mtime_p = sample_time_i;
      fall_p  = '0;
    end else begin
      rmax_p  = rmax_q;
      midx_p  = midx_q;
      mtime_p = mtime_q;
      fall_p  = (falling && fall_q < fcpf_pkg::FALL_MAX) ? fall_q + FallW'(1) : fall_q;
    end

    prev_d  = prev_q;
    rmax_d  = rmax_q;
    midx_d  = midx_q;
    mtime_d = mtime_q;
    pulse_d = pulse_q;
    fall_d  = fall_q;
    cnt_d   = cnt_q;
    any_d   = any_q;

    res_valid_o   = 1'b0;
    res_index_o   = midx_p;
    res_value_o   = rmax_p;
    res_time_o    = mtime_p;
    res_no_peak_o = 1'b0;
    res_eot_o     = last_i;

    if (first_i) begin
      prev_d  = sample_i;
      rmax_d  = '0;
      midx_d  = '0;
      mtime_d = '0;
      pulse_d = 1'b0;
      fall_d  = '0;
      cnt_d   = '0;
      any_d   = 1'b0;
    end else begin
      prev_d = sample_i;
      cnt_d  = cnt_inc;
      if (!pulse_q) begin
        if (falling) begin
          rmax_d = sample_i;
        end else if (sample_i >= thr_q && sample_i >= rmax_q) begin
          rmax_d  = sample_i;
          midx_d  = cnt_inc;
          mtime_d = sample_time_i;
          pulse_d = 1'b1;
        end
      end else begin
        rmax_d  = rmax_p;
        midx_d  = midx_p;
        mtime_d = mtime_p;
        fall_d  = fall_p;
        if (fall_p >= limit_q) begin
          // close the pulse and restart the search from this sample
          res_valid_o = 1'b1;
          any_d   = 1'b1;
          rmax_d  = sample_i;
          midx_d  = cnt_inc;
          mtime_d = sample_time_i;
          pulse_d = 1'b0;
          fall_d  = '0;
        end else if (last_i) begin
          res_valid_o = 1'b1;
          any_d       = 1'b1;
        end
      end
    end

    // trace ended without any reported peak
    if (last_i && !any_d) begin
      res_valid_o   = 1'b1;
      res_index_o   = '0;
      res_value_o   = MarkerValue;
      res_time_o    = '1;
      res_no_peak_o = 1'b1;
      res_eot_o     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      rmax_q  <= '0;
      midx_q  <= '0;
      mtime_q <= '0;
      pulse_q <= 1'b0;
      fall_q  <= '0;
      cnt_q   <= '0;
      any_q   <= 1'b0;
    end else if (step_i) begin
      prev_q  <= prev_d;
      rmax_q  <= rmax_d;
      midx_q  <= midx_d;
      mtime_q <= mtime_d;
      pulse_q <= pulse_d;
      fall_q  <= fall_d;
      cnt_q   <= cnt_d;
      any_q   <= any_d;
    end
  end

endmodule

FILE: design/fcpf_out_buf.sv
// two-entry result register with skid slot
module fcpf_out_buf #(
  parameter int WIDTH = 66
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             space_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] data_o
);

  logic [1:0]       count_q, count_d;
  logic [WIDTH-1:0] head_q, head_d;
  logic [WIDTH-1:0] skid_q, skid_d;
  logic             pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = count_q != 2'd0;
  assign space_o = count_q != 2'd2;
  assign data_o  = head_q;

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    skid_d  = skid_q;
    case (count_q)
      2'd0: begin
        if (push_i) begin
          head_d  = data_i;
          count_d = 2'd1;
        end
      end
      2'd1: begin
        if (push_i && pop) begin
          head_d = data_i;
        end else if (push_i) begin
          skid_d  = data_i;
          count_d = 2'd2;
        end else if (pop) begin
          count_d = 2'd0;
        end
      end
      2'd2: begin
        // no push here: the input side is held off while both slots are full
        if (pop) begin
          head_d  = skid_q;
          count_d = 2'd1;
        end
      end
      default: count_d = 2'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

endmodule

FILE: design/falling_count_peak_finder_unit.sv
// top level of the falling-count peak finder
// The unit takes one sample per clock cycle and does the whole peak decision
// for a sample in the cycle it is transferred, updating the trace state and
// writing any result into a two-entry output buffer, whose registered head
// drives the output. Input ready depends only on the buffer fill: samples
// keep flowing while one result waits, and are held off only when both
// buffer slots are occupied. Configuration writes take effect on the next
// clock edge and must be made while idle.
module falling_count_peak_finder_unit #(
  parameter int MAX_TRACE_LENGTH = 65536,
  parameter int SAMPLE_BITS      = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  fcpf_in_if.sink                        in_i,
  fcpf_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [fcpf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [((SAMPLE_BITS > fcpf_pkg::FALL_W) ? SAMPLE_BITS : fcpf_pkg::FALL_W)-1:0]
                                         cfg_data_i
);

  localparam int CfgW  = (SAMPLE_BITS > fcpf_pkg::FALL_W) ? SAMPLE_BITS : fcpf_pkg::FALL_W;
  localparam int ResW  = fcpf_pkg::IDX_W + SAMPLE_BITS + fcpf_pkg::TIME_W + 2;

  logic                          step;
  logic                          space;
  logic                          res_valid;
  logic [fcpf_pkg::IDX_W-1:0]    res_index;
  logic signed [SAMPLE_BITS-1:0] res_value;
  logic [fcpf_pkg::TIME_W-1:0]   res_time;
  logic                          res_no_peak;
  logic                          res_eot;
  logic [ResW-1:0]               buf_in;
  logic [ResW-1:0]               buf_out;

  assign in_i.ready = space;
  assign step       = in_i.valid && space;

  fcpf_core #(
    .MAX_TRACE_LENGTH (MAX_TRACE_LENGTH),
    .SAMPLE_BITS      (SAMPLE_BITS),
    .CFG_W            (CfgW)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .step_i        (step),
    .sample_i      (in_i.sample),
    .sample_time_i (in_i.sample_time),
    .first_i       (in_i.first_of_trace),
    .last_i        (in_i.last_of_trace),
    .res_valid_o   (res_valid),
    .res_index_o   (res_index),
    .res_value_o   (res_value),
    .res_time_o    (res_time),
    .res_no_peak_o (res_no_peak),
    .res_eot_o     (res_eot)
  );

  assign buf_in = {res_index, res_value, res_time, res_no_peak, res_eot};

  fcpf_out_buf #(
    .WIDTH (ResW)
  ) u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step && res_valid),
    .data_i  (buf_in),
    .space_o (space),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (buf_out)
  );

  assign {out_o.peak_index, out_o.peak_value, out_o.peak_time,
          out_o.no_peak, out_o.end_of_trace} = buf_out;

endmodule
